/* src/dcc_pkg.sv */
// ---------------------------------------------------------------------------
// dcc_pkg
// shared constants, control word layout and microprogram of the day count to
// calendar date converter
// ---------------------------------------------------------------------------
package dcc_pkg;

  localparam int DAY_COUNT_BITS_DEF = 16;
  localparam int IN_SOD_BITS        = 17;
  localparam int ACC_BITS           = 17;
  localparam int PC_BITS            = 3;

  localparam logic [ACC_BITS-1:0] SECONDS_PER_DAY = 17'd86400;
  localparam logic [ACC_BITS-1:0] SECONDS_PER_HR  = 17'd3600;
  localparam logic [ACC_BITS-1:0] SECONDS_PER_MIN = 17'd60;
  localparam logic [ACC_BITS-1:0] DAYS_COMMON     = 17'd365;
  localparam logic [ACC_BITS-1:0] DAYS_LEAP       = 17'd366;

  // micro-ops
  localparam logic [2:0] OP_SUB_LOOP  = 3'd0;
  localparam logic [2:0] OP_STORE_DAY = 3'd1;
  localparam logic [2:0] OP_LOAD_SOD  = 3'd2;
  localparam logic [2:0] OP_JUMP_GE   = 3'd3;
  localparam logic [2:0] OP_FINISH    = 3'd4;

  // subtrahend selects
  localparam logic [2:0] SEL_YEAR   = 3'd0;
  localparam logic [2:0] SEL_MONTH  = 3'd1;
  localparam logic [2:0] SEL_HOUR   = 3'd2;
  localparam logic [2:0] SEL_MINUTE = 3'd3;
  localparam logic [2:0] SEL_DAYSEC = 3'd4;

  // program steps
  localparam logic [PC_BITS-1:0] STEP_YEARS   = 3'd0;
  localparam logic [PC_BITS-1:0] STEP_MONTHS  = 3'd1;
  localparam logic [PC_BITS-1:0] STEP_DAY     = 3'd2;
  localparam logic [PC_BITS-1:0] STEP_SOD     = 3'd3;
  localparam logic [PC_BITS-1:0] STEP_CHECK   = 3'd4;
  localparam logic [PC_BITS-1:0] STEP_HOURS   = 3'd5;
  localparam logic [PC_BITS-1:0] STEP_MINUTES = 3'd6;
  localparam logic [PC_BITS-1:0] STEP_FINISH  = 3'd7;

  typedef struct packed {
    logic [2:0]         op;
    logic [2:0]         sel;
    logic [PC_BITS-1:0] target;
  } uword_t;

  typedef struct packed {
    logic [7:0] year_offset;
    logic [3:0] month_number;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
    logic [2:0] weekday;
    logic       bad_second;
  } result_t;

  // microprogram rom
  function automatic uword_t ucode(input logic [PC_BITS-1:0] pc);
    uword_t w;
    w = '{op: OP_FINISH, sel: SEL_YEAR, target: STEP_FINISH};
    case (pc)
      STEP_YEARS:   w = '{op: OP_SUB_LOOP,  sel: SEL_YEAR,   target: STEP_YEARS};
      STEP_MONTHS:  w = '{op: OP_SUB_LOOP,  sel: SEL_MONTH,  target: STEP_MONTHS};
      STEP_DAY:     w = '{op: OP_STORE_DAY, sel: SEL_YEAR,   target: STEP_DAY};
      STEP_SOD:     w = '{op: OP_LOAD_SOD,  sel: SEL_YEAR,   target: STEP_SOD};
      STEP_CHECK:   w = '{op: OP_JUMP_GE,   sel: SEL_DAYSEC, target: STEP_FINISH};
      STEP_HOURS:   w = '{op: OP_SUB_LOOP,  sel: SEL_HOUR,   target: STEP_HOURS};
      STEP_MINUTES: w = '{op: OP_SUB_LOOP,  sel: SEL_MINUTE, target: STEP_MINUTES};
      default:      w = '{op: OP_FINISH,    sel: SEL_YEAR,   target: STEP_FINISH};
    endcase
    return w;
  endfunction

  // month length, month index 0 is january
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1:                       len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* src/dcc_mod7.sv */
// ---------------------------------------------------------------------------
// dcc_mod7
// day count modulo 7 by folding octal digits, giving the weekday
// ---------------------------------------------------------------------------
module dcc_mod7 import dcc_pkg::*; #(
  parameter int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      start,
  input  logic [DAY_COUNT_BITS-1:0] days,
  output logic [2:0]                weekday
);

  localparam int DIGITS   = (DAY_COUNT_BITS + 2) / 3;
  localparam int PAD_BITS = 3 * DIGITS;

  logic [PAD_BITS-1:0] padded;
  logic [5:0]          digit_sum;
  logic [5:0]          total;
  logic [3:0]          fold;
  logic [2:0]          folded;
  logic [2:0]          r;

  // 8 is 1 mod 7, so the octal digits of the count leave the same remainder
  assign padded = PAD_BITS'(days);

  always_comb begin
    digit_sum = '0;
    for (int i = 0; i < DIGITS; i++) begin
      digit_sum = digit_sum + 6'(padded[3*i +: 3]);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      total <= digit_sum;
    end
  end

  // at most 42 folds to at most 14, then to at most 7
  assign fold   = 4'(total[5:3]) + 4'(total[2:0]);
  assign folded = fold[2:0] + 3'(fold[3]);
  assign r      = (folded == 3'd7) ? 3'd0 : folded;

  // day 0 was a saturday
  assign weekday = (r == 3'd0) ? 3'd6 : 3'(r - 3'd1);

endmodule

/* src/dcc_seq.sv */
// ---------------------------------------------------------------------------
// dcc_seq
// microcoded sequencer with its subtract-and-count datapath
// ---------------------------------------------------------------------------
module dcc_seq import dcc_pkg::*; #(
  parameter int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DAY_COUNT_BITS-1:0] days,
  input  logic [IN_SOD_BITS-1:0]    sod,
  input  logic                      out_free,
  output logic                      idle,
  output logic                      fire,
  output result_t                   result
);

  logic                   active;
  logic [PC_BITS-1:0]     pc;
  uword_t                 uw;
  logic [ACC_BITS-1:0]    acc;
  logic [IN_SOD_BITS-1:0] sod_hold;
  logic [7:0]             year;
  logic [3:0]             month;
  logic [4:0]             day;
  logic [4:0]             hour;
  logic [5:0]             minute;
  logic                   bad;
  logic [1:0]             c4;
  logic [6:0]             c100;
  logic [8:0]             c400;
  logic                   leap;
  logic [ACC_BITS-1:0]    sub;
  logic                   ge;
  logic [2:0]             weekday;

  dcc_mod7 #(.DAY_COUNT_BITS(DAY_COUNT_BITS)) u_mod7 (
    .clk     (clk),
    .start   (start),
    .days    (days),
    .weekday (weekday)
  );

  assign uw   = ucode(pc);
  assign leap = ((c4 == 2'd0) && (c100 != 7'd0)) || (c400 == 9'd0);

  always_comb begin
    case (uw.sel)
      SEL_YEAR:   sub = leap ? DAYS_LEAP : DAYS_COMMON;
      SEL_MONTH:  sub = ACC_BITS'(month_len(month, leap));
      SEL_HOUR:   sub = SECONDS_PER_HR;
      SEL_MINUTE: sub = SECONDS_PER_MIN;
      default:    sub = SECONDS_PER_DAY;
    endcase
  end

  assign ge   = (acc >= sub);
  assign idle = !active;
  assign fire = active && (uw.op == OP_FINISH) && out_free;

  assign result = '{
    year_offset:      year,
    month_number:     month + 4'd1,
    day_of_month:     day,
    hour_of_day:      hour,
    minute_of_hour:   minute,
    second_of_minute: bad ? 6'd0 : acc[5:0],
    weekday:          weekday,
    bad_second:       bad
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pc     <= STEP_YEARS;
    end else if (start) begin
      active <= 1'b1;
      pc     <= STEP_YEARS;
    end else if (active) begin
      unique case (uw.op)
        OP_SUB_LOOP: begin
          if (!ge) pc <= pc + PC_BITS'(1);
        end
        OP_JUMP_GE: begin
          pc <= ge ? uw.target : pc + PC_BITS'(1);
        end
        OP_FINISH: begin
          if (fire) active <= 1'b0;
        end
        default: begin
          pc <= pc + PC_BITS'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc      <= ACC_BITS'(days);
      sod_hold <= sod;
      year     <= 8'd0;
      month    <= 4'd0;
      hour     <= 5'd0;
      minute   <= 6'd0;
      bad      <= 1'b0;
      c4       <= 2'd0;
      c100     <= 7'd0;
      c400     <= 9'd0;
    end else if (active) begin
      case (uw.op)
        OP_SUB_LOOP: begin
          if (ge) begin
            acc <= acc - sub;
            case (uw.sel)
              SEL_YEAR: begin
                year <= year + 8'd1;
                c4   <= c4 + 2'd1;
                c100 <= (c100 == 7'd99)  ? 7'd0 : c100 + 7'd1;
                c400 <= (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
              end
              SEL_MONTH: month  <= month + 4'd1;
              SEL_HOUR:  hour   <= hour + 5'd1;
              default:   minute <= minute + 6'd1;
            endcase
          end
        end
        OP_STORE_DAY: day <= acc[4:0] + 5'd1;
        OP_LOAD_SOD:  acc <= ACC_BITS'(sod_hold);
        OP_JUMP_GE: begin
          if (ge) bad <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

/* src/day_count_to_calendar_date.sv */
// sequence: whole years and then months are peeled off the day count by subtraction,
//   the day is stored, the second of day is loaded and checked, then hours and minutes are peeled off;
//   a flagged second skips the hour and minute loops
// items: one at a time, the next is taken once the result is in the output register
// reset: synchronous active-high rst empties the sequencer and the output register
// ---------------------------------------------------------------------------
// day_count_to_calendar_date
// converts days since 2000-01-01 and second of day into calendar date, time of
// day and weekday, using a microcoded subtract-and-count sequencer
// ---------------------------------------------------------------------------
module day_count_to_calendar_date import dcc_pkg::*; #(
  parameter int DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // input items
  input  logic s_tvalid,
  output logic s_tready,
  // day_count [DAY_COUNT_BITS-1:0], second_of_day [DAY_COUNT_BITS+16:DAY_COUNT_BITS],
  // zero padded to whole bytes
  input  logic [((DAY_COUNT_BITS + IN_SOD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // result items
  output logic m_tvalid,
  input  logic m_tready,
  // year_offset [7:0], month_number [11:8], day_of_month [16:12], hour_of_day [21:17],
  // minute_of_hour [27:22], second_of_minute [33:28], weekday [36:34], zeros [39:37]
  output logic [39:0] m_tdata,
  // bad_second [0]
  output logic        m_tuser
);

  localparam int OUT_USED = 37;

  logic    start;
  logic    idle;
  logic    fire;
  logic    out_free;
  result_t result;

  // the sequencer takes a new item only when it has handed off the last one
  assign s_tready = idle;
  assign start    = s_tvalid && s_tready;
  // output register frees up in the same cycle its item is taken
  assign out_free = !m_tvalid || m_tready;

  dcc_seq #(.DAY_COUNT_BITS(DAY_COUNT_BITS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .days     (s_tdata[DAY_COUNT_BITS-1:0]),
    .sod      (s_tdata[DAY_COUNT_BITS+IN_SOD_BITS-1:DAY_COUNT_BITS]),
    .out_free (out_free),
    .idle     (idle),
    .fire     (fire),
    .result   (result)
  );

  // output register, parts the sequencer from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {(40 - OUT_USED)'(0), result.weekday, result.second_of_minute,
                  result.minute_of_hour, result.hour_of_day, result.day_of_month,
                  result.month_number, result.year_offset};
      m_tuser <= result.bad_second;
    end
  end

  // the sequencer is busy in the cycle after it accepts an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !s_tready)
    else $error("sequencer ready right after accepting an item");

  // month is always in calendar range and day of month is never zero
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:8] >= 4'd1) && (m_tdata[11:8] <= 4'd12) &&
                 (m_tdata[16:12] != 5'd0))
    else $error("month or day of month out of range");

  // weekday never reaches seven
  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[36:34] <= 3'd6))
    else $error("weekday out of range");

  // valid second of day gives a valid time of day
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[21:17] <= 5'd23) && (m_tdata[27:22] <= 6'd59) &&
                             (m_tdata[33:28] <= 6'd59))
    else $error("time of day out of range");

  // flagged second gives a zero time of day
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[33:17] == 17'd0))
    else $error("time of day not cleared on bad second");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// checks day_count_to_calendar_date against an in-bench calendar predictor,
// with directed boundary dates, random dates and random stalls on both sides
// ---------------------------------------------------------------------------
module tb;
  import dcc_pkg::*;

  localparam int          DAY_BITS   = DAY_COUNT_BITS_DEF;
  localparam int          IN_BITS    = ((DAY_BITS + IN_SOD_BITS + 7) / 8) * 8;
  localparam int unsigned RANDOM_NUM = 1400;
  // the drain tail and the timeout are sized from the longest item
  localparam int unsigned TAIL_CYCLES = 300;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  // predictor and store of pending calendar dates
  class calendar_scoreboard;
    result_t     pending_dates[$];
    int unsigned errors;
    // first day of each month, counted from january 1 of a common year
    int unsigned month_first[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    function automatic bit leap_year(int unsigned year);
      return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    function automatic result_t to_calendar(logic [DAY_BITS-1:0] days,
                                            logic [IN_SOD_BITS-1:0] sod);
      int unsigned year;
      int unsigned left;
      int unsigned mon;
      int unsigned first;
      bit          leap;
      result_t     r;
      year = 2000;
      left = days;
      // peel whole years off the day count
      while (left >= (leap_year(year) ? 366 : 365)) begin
        left -= leap_year(year) ? 366 : 365;
        year++;
      end
      leap = leap_year(year);
      mon  = 0;
      for (int unsigned m = 1; m < 12; m++) begin
        first = month_first[m] + ((leap && m >= 2) ? 1 : 0);
        if (left >= first) mon = m;
      end
      left -= month_first[mon] + ((leap && mon >= 2) ? 1 : 0);
      r.year_offset  = 8'(year - 2000);
      r.month_number = 4'(mon + 1);
      r.day_of_month = 5'(left + 1);
      r.weekday      = 3'(((days % 7) + 6) % 7);  // 2000-01-01 was a saturday
      if (sod >= 86400) begin
        r.bad_second       = 1'b1;
        r.hour_of_day      = '0;
        r.minute_of_hour   = '0;
        r.second_of_minute = '0;
      end else begin
        r.bad_second       = 1'b0;
        r.hour_of_day      = 5'(sod / 3600);
        r.minute_of_hour   = 6'((sod % 3600) / 60);
        r.second_of_minute = 6'(sod % 60);
      end
      return r;
    endfunction

    function void note_input(logic [DAY_BITS-1:0] days, logic [IN_SOD_BITS-1:0] sod);
      pending_dates.push_back(to_calendar(days, sod));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_dates.size() == 0) begin
        $error("result item with no input pending");
        errors++;
        return;
      end
      want = pending_dates.pop_front();
      compare_field("year_offset", want.year_offset, got.year_offset);
      compare_field("month_number", want.month_number, got.month_number);
      compare_field("day_of_month", want.day_of_month, got.day_of_month);
      compare_field("hour_of_day", want.hour_of_day, got.hour_of_day);
      compare_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
      compare_field("second_of_minute", want.second_of_minute, got.second_of_minute);
      compare_field("weekday", want.weekday, got.weekday);
      compare_field("bad_second", want.bad_second, got.bad_second);
    endfunction
  endclass

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // day_count [15:0], second_of_day [32:16], zeros [39:33]
  logic [IN_BITS-1:0] s_tdata  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // year_offset [7:0], month_number [11:8], day_of_month [16:12], hour_of_day [21:17],
  // minute_of_hour [27:22], second_of_minute [33:28], weekday [36:34], zeros [39:37]
  logic [39:0]        m_tdata;
  // bad_second [0]
  logic               m_tuser;

  calendar_scoreboard books = new;
  longint unsigned    cycles = 0;
  bit                 quiet  = 1'b0;  // both sides run flat out while set

  day_count_to_calendar_date #(.DAY_COUNT_BITS(DAY_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("day_count_to_calendar_date test failed");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long, and quiet stretches with none
  function automatic int unsigned pick_gap();
    int unsigned r;
    if ($urandom_range(0, 79) == 0) quiet = !quiet;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one item and hold it until the block takes it
  task automatic send_item(logic [DAY_BITS-1:0] days, logic [IN_SOD_BITS-1:0] sod);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_BITS'({sod, days});
    do @(posedge clk); while (!s_tready);
    books.note_input(days, sod);
  endtask

  // sender holds off until every pending date has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (books.pending_dates.size() != 0) @(posedge clk);
  endtask

  // second of day: mostly legal, some on hour and minute edges, some out of range
  function automatic logic [IN_SOD_BITS-1:0] pick_sod();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return IN_SOD_BITS'($urandom_range(86400, 131071));
    if (r < 20) begin
      case ($urandom_range(0, 5))
        0:       return 0;
        1:       return 59;
        2:       return 60;
        3:       return 3599;
        4:       return 3600;
        default: return 86399;
      endcase
    end
    return IN_SOD_BITS'($urandom_range(0, 86399));
  endfunction

  // sender
  initial begin
    logic [DAY_BITS-1:0] days;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: epoch, month and year edges, leap day, the non-leap century,
    // top of the day range, second edges and out-of-range seconds
    send_item(0, 0);
    send_item(30, 59);
    send_item(31, 60);
    send_item(58, 3599);
    send_item(59, 3600);
    send_item(60, 86399);
    send_item(365, 86400);
    send_item(366, 131071);
    send_item(424, 43210);
    send_item(425, 65536);
    send_item(1460, 1);
    send_item(1461, 86340);
    send_item(36524, 82800);
    send_item(36525, 0);
    send_item(36583, 86399);
    send_item(36584, 100000);
    send_item(65534, 3661);
    send_item(65535, 86399);
    send_item(65535, 131071);
    send_item(0, 131071);
    drain_results();

    // random dates, with one full hold-off halfway
    for (int unsigned i = 0; i < RANDOM_NUM; i++) begin
      if (i == RANDOM_NUM / 2) drain_results();
      // some early dates keep the year loop short
      if ($urandom_range(0, 7) == 0) days = DAY_BITS'($urandom_range(0, 1500));
      else days = DAY_BITS'($urandom_range(0, 65535));
      send_item(days, pick_sod());
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (books.errors == 0) begin
      $display("day_count_to_calendar_date test passed");
    end else begin
      $display("day_count_to_calendar_date test failed");
    end
    $finish;
  end

  // receiver: random stalls, every accepted result goes to the scoreboard
  initial begin
    int unsigned stall;
    result_t     seen;
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      // values read here are the ones present at the accepting edge
      seen.year_offset      = m_tdata[7:0];
      seen.month_number     = m_tdata[11:8];
      seen.day_of_month     = m_tdata[16:12];
      seen.hour_of_day      = m_tdata[21:17];
      seen.minute_of_hour   = m_tdata[27:22];
      seen.second_of_minute = m_tdata[33:28];
      seen.weekday          = m_tdata[36:34];
      seen.bad_second       = m_tuser;
      books.check_result(seen);
    end
  end

endmodule
